// ===== rtl/htwp_pkg.sv =====
// Shared types, character codes and helpers of the hex text word parser.
`timescale 1ns / 1ps
`default_nettype none

package htwp_pkg;

  // Defaults for the top-level parameters.
  localparam int POSITION_WIDTH_DEF  = 16;
  localparam int DIGITS_PER_WORD_DEF = 4;

  // Fixed widths of the result fields.
  localparam int FIELD_WIDTH = 16;

  // Entries in the result queue; two must be free before an item is processed.
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;

  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_UNEXPECTED   = 2'd0,
    ERR_PARTIAL      = 2'd1,
    ERR_UNTERMINATED = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4,
    MODE_HALT   = 3'd5
  } mode_t;

  typedef struct packed {
    kind_t                  kind;
    logic [FIELD_WIDTH-1:0] word_value;
    logic [FIELD_WIDTH-1:0] line_number;
    logic [FIELD_WIDTH-1:0] column_number;
    err_t                   error_code;
    logic                   final_result;
  } result_t;

  // Up to two results written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      h.value = 4'(c - CHAR_ZERO);
    end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
      h.value = 4'(c - CHAR_LOWER_A + 8'd10);
    end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
      h.value = 4'(c - CHAR_UPPER_A + 8'd10);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/htwp_char_if.sv =====
// Character channel: one text byte and its end flag per request.
`timescale 1ns / 1ps
`default_nettype none

interface htwp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/htwp_result_if.sv =====
// Result channel: one parsed word, error or end marker per request.
`timescale 1ns / 1ps
`default_nettype none

interface htwp_result_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [htwp_pkg::FIELD_WIDTH-1:0] word_value;
  logic [htwp_pkg::FIELD_WIDTH-1:0] line_number;
  logic [htwp_pkg::FIELD_WIDTH-1:0] column_number;
  logic [1:0]                      error_code;
  logic                            final_result;

  modport source (output valid, output kind, output word_value, output line_number,
                  output column_number, output error_code, output final_result,
                  input ready);
  modport sink (input valid, input kind, input word_value, input line_number,
                input column_number, input error_code, input final_result,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/hex_text_word_parser.sv =====
// Hex text word parser: turns a stream of text characters into 16-bit words.
// Input channel "chars" carries one byte per request with an end flag on the
// last byte of a text. Output channel "results" carries parsed words, syntax
// errors and the end marker, each with a line and column; final_result marks
// the last result that one character causes.
// A character is taken into an input register, decoded in one pass against
// the scan state once the queue has room, and its results land in a
// four-entry result queue. One character is accepted every cycle while at
// least two queue entries are free; only the end-flagged character may make
// two results. Acceptance depends on the input register and the registered
// queue occupancy: the input stalls when the register is full and fewer than
// two entries are free, so a stalled receiver backs up into the input after
// the queue fills, and nothing is lost or repeated.
// Reset empties the queue and the input register and puts the scanner at
// line 1, column 0, outside any comment, with no partial word.
`timescale 1ns / 1ps
`default_nettype none

module hex_text_word_parser #(
  parameter int POSITION_WIDTH  = htwp_pkg::POSITION_WIDTH_DEF,
  parameter int DIGITS_PER_WORD = htwp_pkg::DIGITS_PER_WORD_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  htwp_char_if.sink     chars,
  htwp_result_if.source results
);

  htwp_pkg::push_t push;
  logic            room;

  htwp_scanner #(
    .POSITION_WIDTH  (POSITION_WIDTH),
    .DIGITS_PER_WORD (DIGITS_PER_WORD)
  ) u_scanner (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .room  (room),
    .push  (push)
  );

  htwp_result_fifo u_result_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .results (results)
  );

endmodule

`default_nettype wire

// ===== rtl/htwp_scanner.sv =====
// Input register, scan state and the single-pass character decode.
`timescale 1ns / 1ps
`default_nettype none

module htwp_scanner #(
  parameter int POSITION_WIDTH  = htwp_pkg::POSITION_WIDTH_DEF,
  parameter int DIGITS_PER_WORD = htwp_pkg::DIGITS_PER_WORD_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  htwp_char_if.sink            chars,
  input  wire logic            room,
  output htwp_pkg::push_t      push
);

  localparam int PW = POSITION_WIDTH;
  localparam int AW = 4 * DIGITS_PER_WORD;
  localparam int CW = (DIGITS_PER_WORD > 1) ? $clog2(DIGITS_PER_WORD) : 1;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
  localparam int FW = htwp_pkg::FIELD_WIDTH;

  // Input register.
  logic       stage_valid;
  logic [7:0] stage_char;
  logic       stage_last;

  // Scan state.
  htwp_pkg::mode_t mode, mode_next;
  logic [CW-1:0]   digit_count;
  logic [AW-1:0]   acc;
  logic [PW-1:0]   line;
  logic [PW-1:0]   column;
  logic [PW-1:0]   word_line;
  logic [PW-1:0]   word_column;
  logic [PW-1:0]   slash_col;

  logic            take;
  logic            fire;
  logic            is_normal;
  logic            is_newline;
  logic            is_space;
  logic            is_slash;
  logic            is_star;
  htwp_pkg::hex_t  hex;
  logic [PW-1:0]   line_new;
  logic [PW-1:0]   column_new;
  logic            digit_first;
  logic            word_done;
  logic [PW-1:0]   start_line;
  logic [PW-1:0]   start_column;
  logic [AW-1:0]   acc_shift;
  logic            slash_bad;
  logic            normal_bad;
  logic            failed;
  logic            in_comment;
  logic            partial;

  assign take   = chars.valid && chars.ready;
  assign fire   = stage_valid && room;
  assign chars.ready = !stage_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
    if (take) begin
      stage_char <= chars.text_char;
      stage_last <= chars.end_of_text;
    end
  end

  // Shared decode of the registered character.
  assign is_normal  = !(mode inside {htwp_pkg::MODE_SLASH, htwp_pkg::MODE_LINE,
                                     htwp_pkg::MODE_BLOCK, htwp_pkg::MODE_STAR,
                                     htwp_pkg::MODE_HALT});
  assign is_newline = (stage_char == htwp_pkg::CHAR_NEWLINE);
  assign is_space   = stage_char inside {htwp_pkg::CHAR_SPACE, htwp_pkg::CHAR_TAB,
                                         htwp_pkg::CHAR_CR, htwp_pkg::CHAR_NEWLINE};
  assign is_slash   = (stage_char == htwp_pkg::CHAR_SLASH);
  assign is_star    = (stage_char == htwp_pkg::CHAR_STAR);
  assign hex        = htwp_pkg::hex_digit(stage_char);

  // Counters saturate at all ones; a newline restarts the column.
  assign line_new   = (is_newline && line != POS_MAX) ? line + PW'(1) : line;
  assign column_new = is_newline ? '0 : ((column == POS_MAX) ? column : column + PW'(1));

  assign digit_first  = (digit_count == '0);
  assign word_done    = (digit_count == CW'(DIGITS_PER_WORD - 1));
  assign start_line   = digit_first ? line : word_line;
  assign start_column = digit_first ? column_new : word_column;
  assign acc_shift    = AW'(acc << 4) | AW'(hex.value);

  assign slash_bad  = (mode == htwp_pkg::MODE_SLASH) && !is_slash && !is_star;
  assign normal_bad = is_normal && !is_space && !hex.valid && !(is_slash && !stage_last);
  assign failed     = slash_bad || normal_bad;

  assign in_comment = (mode == htwp_pkg::MODE_BLOCK)
                   || (mode == htwp_pkg::MODE_STAR && !is_slash)
                   || (mode == htwp_pkg::MODE_SLASH && is_star);
  assign partial    = (is_normal && hex.valid) ? !word_done : !digit_first;

  // Next scan mode.
  always_comb begin
    mode_next = mode;
    if (fire) begin
      if (stage_last) begin
        mode_next = htwp_pkg::MODE_NORMAL;
      end else if (failed) begin
        mode_next = htwp_pkg::MODE_HALT;
      end else begin
        case (mode)
          htwp_pkg::MODE_HALT: begin
            mode_next = htwp_pkg::MODE_HALT;
          end
          htwp_pkg::MODE_SLASH: begin
            mode_next = is_slash ? htwp_pkg::MODE_LINE : htwp_pkg::MODE_BLOCK;
          end
          htwp_pkg::MODE_LINE: begin
            if (is_newline) mode_next = htwp_pkg::MODE_NORMAL;
          end
          htwp_pkg::MODE_BLOCK: begin
            if (is_star) mode_next = htwp_pkg::MODE_STAR;
          end
          htwp_pkg::MODE_STAR: begin
            if (is_slash) mode_next = htwp_pkg::MODE_NORMAL;
            else if (!is_star) mode_next = htwp_pkg::MODE_BLOCK;
          end
          default: begin
            mode_next = is_slash ? htwp_pkg::MODE_SLASH : htwp_pkg::MODE_NORMAL;
          end
        endcase
      end
    end
  end

  // Results of the current character.
  always_comb begin
    htwp_pkg::result_t err_res;
    htwp_pkg::result_t word_res;
    htwp_pkg::result_t end_res;
    logic              emit_word;

    err_res.kind          = htwp_pkg::KIND_ERROR;
    err_res.word_value    = '0;
    err_res.line_number   = slash_bad ? FW'(line) : FW'(line_new);
    err_res.column_number = slash_bad ? FW'(slash_col) : FW'(column_new);
    err_res.error_code    = htwp_pkg::ERR_UNEXPECTED;
    err_res.final_result  = 1'b1;

    word_res.kind          = htwp_pkg::KIND_WORD;
    word_res.word_value    = FW'(acc_shift);
    word_res.line_number   = FW'(start_line);
    word_res.column_number = FW'(start_column);
    word_res.error_code    = htwp_pkg::ERR_UNEXPECTED;
    word_res.final_result  = !stage_last;

    end_res.kind          = htwp_pkg::KIND_END;
    end_res.word_value    = '0;
    end_res.line_number   = FW'(line_new);
    end_res.column_number = FW'(column_new);
    end_res.error_code    = htwp_pkg::ERR_UNEXPECTED;
    end_res.final_result  = 1'b1;
    if (in_comment) begin
      end_res.kind       = htwp_pkg::KIND_ERROR;
      end_res.error_code = htwp_pkg::ERR_UNTERMINATED;
    end else if (partial) begin
      end_res.kind       = htwp_pkg::KIND_ERROR;
      end_res.error_code = htwp_pkg::ERR_PARTIAL;
    end

    emit_word = is_normal && hex.valid && word_done;

    push.first  = end_res;
    push.second = end_res;
    push.count  = 2'd0;
    if (fire && mode != htwp_pkg::MODE_HALT) begin
      if (failed) begin
        push.first = err_res;
        push.count = 2'd1;
      end else if (emit_word) begin
        push.first = word_res;
        push.count = stage_last ? 2'd2 : 2'd1;
      end else if (stage_last) begin
        push.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && stage_last)) begin
      mode        <= htwp_pkg::MODE_NORMAL;
      digit_count <= '0;
      acc         <= '0;
      line        <= PW'(1);
      column      <= '0;
      word_line   <= '0;
      word_column <= '0;
      slash_col   <= '0;
    end else begin
      mode <= mode_next;
      if (fire && mode != htwp_pkg::MODE_HALT) begin
        line   <= line_new;
        column <= column_new;
        if (is_normal && hex.valid) begin
          if (digit_first) begin
            word_line   <= start_line;
            word_column <= start_column;
          end
          if (word_done) begin
            digit_count <= '0;
            acc         <= '0;
          end else begin
            digit_count <= digit_count + CW'(1);
            acc         <= acc_shift;
          end
        end
        if (is_normal && is_slash) begin
          slash_col <= column_new;
        end
      end
    end
  end

  // Only the end-flagged character can carry a second result.
  a_two_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> (fire && stage_last))
    else $error("two results from a character without the end flag");

  // Every end-flagged character starts a new text at line 1, column 0.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    fire && stage_last |=> line == PW'(1) && column == '0
                           && mode == htwp_pkg::MODE_NORMAL && digit_count == '0)
    else $error("scan state not restarted after end of text");

  // A halted scan gives nothing, not even for the end-flagged character.
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    mode == htwp_pkg::MODE_HALT |-> push.count == 2'd0)
    else $error("result produced while halted after an error");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CW'(DIGITS_PER_WORD - 1))
    else $error("digit count beyond one word");

endmodule

`default_nettype wire

// ===== rtl/htwp_result_fifo.sv =====
// Result queue that takes up to two results per cycle and gives one.
`timescale 1ns / 1ps
`default_nettype none

module htwp_result_fifo (
  input  wire logic        clk,
  input  wire logic        rst,
  input  htwp_pkg::push_t  push,
  output logic             room,
  htwp_result_if.source    results
);

  localparam int DEPTH = htwp_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  htwp_pkg::result_t entry [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  wr_ptr_plus;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;
  htwp_pkg::result_t head;

  assign wr_ptr_plus = wr_ptr + PTR_W'(1);
  assign pop         = results.valid && results.ready;
  // Registered occupancy only, so the two sides stay decoupled.
  assign room        = (count <= CNT_W'(DEPTH - 2));
  assign head        = entry[rd_ptr];

  assign results.valid         = (count != '0);
  assign results.kind          = head.kind;
  assign results.word_value    = head.word_value;
  assign results.line_number   = head.line_number;
  assign results.column_number = head.column_number;
  assign results.error_code    = head.error_code;
  assign results.final_result  = head.final_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
    if (push.count != 2'd0) begin
      entry[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry[wr_ptr_plus] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("result written without two free entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue occupancy beyond its depth");

endmodule

`default_nettype wire
